// ===== sv/clfd_pkg.sv =====
// Package for the camera line fault debouncer.
// Holds the transaction and configuration types, register and fault codes and
// the fixed thresholds. No dependencies.
package clfd_pkg;

    localparam int CHANNELS      = 4;
    localparam int SAMPLE_BITS   = 12;
    localparam int CNT_BITS      = 6;
    localparam int ADDR_BITS     = 5;
    localparam int DATA_BITS     = 32;

    localparam logic [CNT_BITS-1:0] SHORT_CONFIRM = CNT_BITS'(5);
    localparam logic [CNT_BITS-1:0] RECOVER_COUNT = CNT_BITS'(5);
    localparam logic [CNT_BITS-1:0] CNT_MAX       = '1;
    localparam logic [CNT_BITS-1:0] OPEN_CONFIRM_RESET = CNT_BITS'(50);

    typedef enum logic [1:0] {
        CODE_NORMAL    = 2'd0,
        CODE_OPEN      = 2'd1,
        CODE_SHORT_BAT = 2'd2,
        CODE_SHORT_GND = 2'd3
    } fault_code_t;

    typedef enum logic [2:0] {
        REG_OPEN_BELOW     = 3'd0,
        REG_SHORT_BAT_LOW  = 3'd1,
        REG_SHORT_BAT_HIGH = 3'd2,
        REG_SHORT_GND_LOW  = 3'd3,
        REG_SHORT_GND_HIGH = 3'd4,
        REG_NORMAL_LOW     = 3'd5,
        REG_NORMAL_HIGH    = 3'd6,
        REG_OPEN_CONFIRM   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]             channel;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   soc_confirms;
        logic                   camera_power_on;
    } req_t;

    typedef struct packed {
        logic [1:0] out_channel;
        logic [1:0] fault_code;
        logic       fault_flag;
        logic       status_updated;
        logic [3:0] fault_bitmap;
    } rsp_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] open_below;
        logic [SAMPLE_BITS-1:0] short_bat_low;
        logic [SAMPLE_BITS-1:0] short_bat_high;
        logic [SAMPLE_BITS-1:0] short_gnd_low;
        logic [SAMPLE_BITS-1:0] short_gnd_high;
        logic [SAMPLE_BITS-1:0] normal_low;
        logic [SAMPLE_BITS-1:0] normal_high;
        logic [CNT_BITS-1:0]    open_confirm_count;
    } cfg_t;

endpackage

// ===== sv/clfd_regs.sv =====
// Configuration register file of the camera line fault debouncer.
// APB-style write and read access to the window bounds and open confirm count.
// Depends on clfd_pkg.
module clfd_regs
    import clfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output cfg_t                 cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                    <= '0;
            cfg_reg.open_confirm_count <= OPEN_CONFIRM_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_OPEN_BELOW:     cfg_reg.open_below     <= pwdata[SAMPLE_BITS-1:0];
                REG_SHORT_BAT_LOW:  cfg_reg.short_bat_low  <= pwdata[SAMPLE_BITS-1:0];
                REG_SHORT_BAT_HIGH: cfg_reg.short_bat_high <= pwdata[SAMPLE_BITS-1:0];
                REG_SHORT_GND_LOW:  cfg_reg.short_gnd_low  <= pwdata[SAMPLE_BITS-1:0];
                REG_SHORT_GND_HIGH: cfg_reg.short_gnd_high <= pwdata[SAMPLE_BITS-1:0];
                REG_NORMAL_LOW:     cfg_reg.normal_low     <= pwdata[SAMPLE_BITS-1:0];
                REG_NORMAL_HIGH:    cfg_reg.normal_high    <= pwdata[SAMPLE_BITS-1:0];
                REG_OPEN_CONFIRM:   cfg_reg.open_confirm_count <= pwdata[CNT_BITS-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_OPEN_BELOW:     prdata = DATA_BITS'(cfg_reg.open_below);
            REG_SHORT_BAT_LOW:  prdata = DATA_BITS'(cfg_reg.short_bat_low);
            REG_SHORT_BAT_HIGH: prdata = DATA_BITS'(cfg_reg.short_bat_high);
            REG_SHORT_GND_LOW:  prdata = DATA_BITS'(cfg_reg.short_gnd_low);
            REG_SHORT_GND_HIGH: prdata = DATA_BITS'(cfg_reg.short_gnd_high);
            REG_NORMAL_LOW:     prdata = DATA_BITS'(cfg_reg.normal_low);
            REG_NORMAL_HIGH:    prdata = DATA_BITS'(cfg_reg.normal_high);
            REG_OPEN_CONFIRM:   prdata = DATA_BITS'(cfg_reg.open_confirm_count);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== sv/clfd_engine.sv =====
// Classification and per-channel debounce state of the fault debouncer.
// Computes the result of the registered transaction and updates the counters.
// Depends on clfd_pkg.
module clfd_engine
    import clfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  req_t item,
    input  cfg_t cfg,
    output rsp_t result
);

    logic [CNT_BITS-1:0] fault_cnt_reg  [CHANNELS];
    logic [CNT_BITS-1:0] fault_cnt_next [CHANNELS];
    logic [CNT_BITS-1:0] norm_cnt_reg   [CHANNELS];
    logic [CNT_BITS-1:0] norm_cnt_next  [CHANNELS];
    logic                flag_reg       [CHANNELS];
    logic                flag_next      [CHANNELS];
    fault_code_t         code_reg       [CHANNELS];
    fault_code_t         code_next      [CHANNELS];

    logic [1:0]          idx;
    logic                ch_ok;
    logic                act;
    logic                is_fault;
    fault_code_t         kind;
    logic [CNT_BITS-1:0] thr;
    logic [CNT_BITS-1:0] fault_inc;
    logic [CNT_BITS-1:0] norm_inc;
    logic                updated;
    logic [3:0]          bitmap;

    assign idx   = item.channel;
    assign ch_ok = (32'(item.channel) < 32'(CHANNELS));

    // Window priority: open, short to battery, short to ground, normal.
    always_comb
    begin
        act      = 1'b1;
        is_fault = 1'b1;
        kind     = CODE_NORMAL;
        thr      = RECOVER_COUNT;
        priority if (item.sample < cfg.open_below)
        begin
            kind = CODE_OPEN;
            thr  = cfg.open_confirm_count;
        end
        else if (item.sample >= cfg.short_bat_low && item.sample < cfg.short_bat_high)
        begin
            kind = CODE_SHORT_BAT;
            thr  = SHORT_CONFIRM;
        end
        else if (item.sample >= cfg.short_gnd_low && item.sample < cfg.short_gnd_high)
        begin
            kind = CODE_SHORT_GND;
            thr  = SHORT_CONFIRM;
        end
        else if (item.sample >= cfg.normal_low && item.sample < cfg.normal_high)
        begin
            is_fault = 1'b0;
        end
        else
        begin
            act = 1'b0;
        end
        if (!(ch_ok && item.camera_power_on && item.soc_confirms))
        begin
            act = 1'b0;
        end
    end

    always_comb
    begin
        fault_cnt_next = fault_cnt_reg;
        norm_cnt_next  = norm_cnt_reg;
        flag_next      = flag_reg;
        code_next      = code_reg;
        updated        = 1'b0;
        fault_inc = (fault_cnt_reg[idx] == CNT_MAX) ? CNT_MAX
                                                    : fault_cnt_reg[idx] + CNT_BITS'(1);
        norm_inc  = (norm_cnt_reg[idx] == CNT_MAX) ? CNT_MAX
                                                   : norm_cnt_reg[idx] + CNT_BITS'(1);
        if (act && is_fault)
        begin
            norm_cnt_next[idx] = '0;
            if (fault_inc >= thr)
            begin
                fault_cnt_next[idx] = '0;
                flag_next[idx]      = 1'b1;
                code_next[idx]      = kind;
                updated             = 1'b1;
            end
            else
            begin
                fault_cnt_next[idx] = fault_inc;
            end
        end
        else if (act)
        begin
            fault_cnt_next[idx] = '0;
            if (norm_inc >= thr)
            begin
                norm_cnt_next[idx] = '0;
                flag_next[idx]     = 1'b0;
                code_next[idx]     = CODE_NORMAL;
                updated            = 1'b1;
            end
            else
            begin
                norm_cnt_next[idx] = norm_inc;
            end
        end
    end

    always_comb
    begin
        bitmap = '0;
        for (int n = 0; n < CHANNELS && n < 4; n++)
        begin
            bitmap[n] = flag_next[n];
        end
    end

    always_comb
    begin
        result.out_channel    = item.channel;
        result.fault_code     = ch_ok ? code_next[idx] : CODE_NORMAL;
        result.fault_flag     = ch_ok ? flag_next[idx] : 1'b0;
        result.status_updated = updated;
        result.fault_bitmap   = bitmap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < CHANNELS; n++)
            begin
                fault_cnt_reg[n] <= '0;
                norm_cnt_reg[n]  <= '0;
                flag_reg[n]      <= 1'b0;
                code_reg[n]      <= CODE_NORMAL;
            end
        end
        else if (advance)
        begin
            fault_cnt_reg <= fault_cnt_next;
            norm_cnt_reg  <= norm_cnt_next;
            flag_reg      <= flag_next;
            code_reg      <= code_next;
        end
    end

endmodule

// ===== sv/camera_line_fault_debouncer_unit.sv =====
// Usage
// Top level of the camera line fault debouncer: input register, debounce engine
// and result register. Depends on clfd_pkg, clfd_regs and clfd_engine.
//
// The req channel carries one converter sample of one camera supply line with
// its SoC-confirm and power bits; the rsp channel returns exactly one result per
// request, in order. A transaction moves on a channel at a clock edge where
// valid is high and stall is low.
// Each accepted request is held in the input register and its result is
// loaded into the result register. Throughput is one request per cycle while
// rsp is not stalled, set by the read-modify-write of the per-channel counters.
// When the receiver stalls rsp, the result register holds; one further request
// waits in the input register, and req_stall rises only when both are full.
// Reset clears all counters, stored codes and flags, empties both registers and
// returns the configuration to its reset values (open confirm count 50).
// Configuration is to be written through the APB port while no request is in
// flight; the block itself does not enforce this.
module camera_line_fault_debouncer_unit
    import clfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    cfg_t cfg;
    req_t item_reg;
    logic item_valid_reg;
    rsp_t rsp_reg;
    logic rsp_valid_reg;
    rsp_t result;
    logic advance;
    logic req_take;

    assign pready    = 1'b1;
    assign advance   = item_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = item_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    clfd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite && pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    clfd_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (req_take)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            item_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= result;
        end
    end

`ifndef SYNTHESIS
    // A stored fault flag is set exactly when the stored code is a fault code.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.fault_flag == (rsp.fault_code != CODE_NORMAL)))
        else $error("fault flag disagrees with stored code");

    // The bitmap carries the flag of the reported channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.fault_bitmap[rsp.out_channel] == rsp.fault_flag))
        else $error("fault bitmap disagrees with channel flag");

    // A request moved into the result stage is presented on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid)
        else $error("result lost after pipeline advance");

    // The input side stalls only while a request waits in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (item_valid_reg && rsp_valid_reg && rsp_stall))
        else $error("input stalled without a blocked pipeline");
`endif

endmodule

// ===== tb/tb_camera_line_fault_debouncer_unit.sv =====
// Self-checking testbench for camera_line_fault_debouncer_unit.
// Drives sample transactions and APB threshold writes, predicts each result
// from its own debounce model and checks it. Depends on clfd_pkg and camera_line_fault_debouncer_unit.
module tb_camera_line_fault_debouncer_unit;
    import clfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [2:0] {
        WIN_OPEN,
        WIN_BAT,
        WIN_GND,
        WIN_NORMAL,
        WIN_NONE
    } sample_class_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_t                 req       = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [ADDR_BITS-1:0] paddr     = '0;
    logic [DATA_BITS-1:0] pwdata    = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    // Shadow of the thresholds and of the per-line debounce state.
    cfg_t                thr_cfg;
    logic [CNT_BITS-1:0] fault_run  [CHANNELS];
    logic [CNT_BITS-1:0] normal_run [CHANNELS];
    logic                line_flag  [CHANNELS];
    fault_code_t         line_code  [CHANNELS];

    req_t sample_backlog[$];
    rsp_t expected_status[$];

    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_rsp       = 1'b0;
    logic pressure_go    = 1'b0;

    camera_line_fault_debouncer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_camera_line_fault_debouncer_unit: errors");
            $finish;
        end
    end

    function automatic rsp_t debounce_line(req_t r);
        rsp_t                o;
        logic [1:0]          ch;
        logic [CNT_BITS-1:0] thr;
        fault_code_t         kind;
        logic                act;
        logic                is_fault;
        ch       = r.channel;
        o        = '0;
        act      = 1'b0;
        is_fault = 1'b1;
        kind     = CODE_NORMAL;
        thr      = '0;
        if (r.camera_power_on && r.soc_confirms)
        begin
            act = 1'b1;
            if (r.sample < thr_cfg.open_below)
            begin
                kind = CODE_OPEN;
                thr  = thr_cfg.open_confirm_count;
            end
            else if (r.sample >= thr_cfg.short_bat_low && r.sample < thr_cfg.short_bat_high)
            begin
                kind = CODE_SHORT_BAT;
                thr  = SHORT_CONFIRM;
            end
            else if (r.sample >= thr_cfg.short_gnd_low && r.sample < thr_cfg.short_gnd_high)
            begin
                kind = CODE_SHORT_GND;
                thr  = SHORT_CONFIRM;
            end
            else if (r.sample >= thr_cfg.normal_low && r.sample < thr_cfg.normal_high)
            begin
                is_fault = 1'b0;
                thr      = RECOVER_COUNT;
            end
            else
                act = 1'b0;
        end
        if (act && is_fault)
        begin
            // The fault counter is shared by all three fault kinds of a line.
            if (fault_run[ch] != CNT_MAX)
                fault_run[ch] = fault_run[ch] + CNT_BITS'(1);
            normal_run[ch] = '0;
            if (fault_run[ch] >= thr)
            begin
                fault_run[ch]    = '0;
                line_flag[ch]    = 1'b1;
                line_code[ch]    = kind;
                o.status_updated = 1'b1;
            end
        end
        else if (act)
        begin
            fault_run[ch] = '0;
            if (normal_run[ch] != CNT_MAX)
                normal_run[ch] = normal_run[ch] + CNT_BITS'(1);
            if (normal_run[ch] >= thr)
            begin
                normal_run[ch]   = '0;
                line_flag[ch]    = 1'b0;
                line_code[ch]    = CODE_NORMAL;
                o.status_updated = 1'b1;
            end
        end
        o.out_channel  = ch;
        o.fault_code   = line_code[ch];
        o.fault_flag   = line_flag[ch];
        o.fault_bitmap = {line_flag[3], line_flag[2], line_flag[1], line_flag[0]};
        return o;
    endfunction

    // Sender: presents queued samples and records the prediction on acceptance.
    always @(posedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            if (req_valid && !req_stall)
                expected_status.push_back(debounce_line(req));
            if (!req_valid || !req_stall)
            begin
                if (sample_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    req       <= sample_backlog.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    task automatic compare_field(string field, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", field, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Receiver: checks each accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_status.size() == 0)
                begin
                    $error("result transaction for line %0d with no prediction waiting",
                           rsp.out_channel);
                    mismatch_count++;
                end
                else
                begin
                    exp_rsp = expected_status.pop_front();
                    compare_field("out_channel", exp_rsp.out_channel, rsp.out_channel);
                    compare_field("fault_code", exp_rsp.fault_code, rsp.fault_code);
                    compare_field("fault_flag", exp_rsp.fault_flag, rsp.fault_flag);
                    compare_field("status_updated", exp_rsp.status_updated,
                                  rsp.status_updated);
                    compare_field("fault_bitmap", exp_rsp.fault_bitmap, rsp.fault_bitmap);
                end
            end
            rsp_stall <= hold_rsp || ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    // Long receiver hold-off so that both internal registers fill and req_stall rises.
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (300) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    task automatic write_reg(reg_idx_t idx, logic [DATA_BITS-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OPEN_BELOW:     thr_cfg.open_below         = value[SAMPLE_BITS-1:0];
            REG_SHORT_BAT_LOW:  thr_cfg.short_bat_low      = value[SAMPLE_BITS-1:0];
            REG_SHORT_BAT_HIGH: thr_cfg.short_bat_high     = value[SAMPLE_BITS-1:0];
            REG_SHORT_GND_LOW:  thr_cfg.short_gnd_low      = value[SAMPLE_BITS-1:0];
            REG_SHORT_GND_HIGH: thr_cfg.short_gnd_high     = value[SAMPLE_BITS-1:0];
            REG_NORMAL_LOW:     thr_cfg.normal_low         = value[SAMPLE_BITS-1:0];
            REG_NORMAL_HIGH:    thr_cfg.normal_high        = value[SAMPLE_BITS-1:0];
            REG_OPEN_CONFIRM:   thr_cfg.open_confirm_count = value[CNT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic program_windows(int ob, int bl, int bh, int gl, int gh,
                                   int nl, int nh, int occ);
        write_reg(REG_OPEN_BELOW, ob);
        write_reg(REG_SHORT_BAT_LOW, bl);
        write_reg(REG_SHORT_BAT_HIGH, bh);
        write_reg(REG_SHORT_GND_LOW, gl);
        write_reg(REG_SHORT_GND_HIGH, gh);
        write_reg(REG_NORMAL_LOW, nl);
        write_reg(REG_NORMAL_HIGH, nh);
        write_reg(REG_OPEN_CONFIRM, occ);
    endtask

    task automatic queue_item(logic [1:0] ch, logic [SAMPLE_BITS-1:0] smp,
                              logic confirm, logic power);
        req_t r;
        r.channel         = ch;
        r.sample          = smp;
        r.soc_confirms    = confirm;
        r.camera_power_on = power;
        sample_backlog.push_back(r);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(sample_class_t cls);
        int unsigned lo;
        int unsigned hi;
        int unsigned pick;
        lo = 0;
        hi = 0;
        case (cls)
            WIN_OPEN:   hi = thr_cfg.open_below;
            WIN_BAT:    begin lo = thr_cfg.short_bat_low; hi = thr_cfg.short_bat_high; end
            WIN_GND:    begin lo = thr_cfg.short_gnd_low; hi = thr_cfg.short_gnd_high; end
            WIN_NORMAL: begin lo = thr_cfg.normal_low;    hi = thr_cfg.normal_high;    end
            default: ;
        endcase
        if (hi <= lo)
            return SAMPLE_BITS'($urandom_range(4095, 0));
        // Lean on the window edges now and then.
        pick = $urandom_range(9, 0);
        if (pick == 0)
            return SAMPLE_BITS'(lo);
        if (pick == 1)
            return SAMPLE_BITS'(hi - 1);
        return SAMPLE_BITS'($urandom_range(hi - 1, lo));
    endfunction

    // Mostly runs of one line in one window, which is what reaches the thresholds.
    task automatic random_traffic(int target, int open_run_max);
        int            placed;
        int            len;
        logic [1:0]    ch;
        sample_class_t cls;
        placed = 0;
        while (placed < target)
        begin
            if ($urandom_range(99, 0) < 85)
            begin
                ch  = 2'($urandom_range(3, 0));
                cls = sample_class_t'($urandom_range(3, 0));
                len = (cls == WIN_OPEN) ? $urandom_range(open_run_max, 1)
                                        : $urandom_range(8, 1);
                repeat (len)
                begin
                    if ($urandom_range(99, 0) < 93)
                        queue_item(ch, pick_sample(cls), 1'b1, 1'b1);
                    else
                        queue_item(ch, pick_sample(cls), 1'($urandom_range(1, 0)),
                                   1'($urandom_range(1, 0)));
                end
                placed += len;
            end
            else
            begin
                queue_item(2'($urandom_range(3, 0)), pick_sample(WIN_NONE),
                           1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
                placed++;
            end
        end
    endtask

    task automatic wait_drained();
        while (sample_backlog.size() != 0 || req_valid || expected_status.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_idling(int send_idle, int recv_stall);
        @(negedge clk);
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
    endtask

    initial
    begin
        thr_cfg                    = '0;
        thr_cfg.open_confirm_count = OPEN_CONFIRM_RESET;
        for (int n = 0; n < CHANNELS; n++)
        begin
            fault_run[n]  = '0;
            normal_run[n] = '0;
            line_flag[n]  = 1'b0;
            line_code[n]  = CODE_NORMAL;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Plain windows, open confirmed after three samples, no idling.
        program_windows(200, 3800, 4095, 200, 400, 1500, 2500, 3);
        set_idling(0, 0);
        queue_item(2'd0, 12'd0, 1'b1, 1'b0);          // power off
        queue_item(2'd0, 12'd0, 1'b0, 1'b1);          // SoC has not confirmed
        repeat (3) queue_item(2'd0, 12'd0, 1'b1, 1'b1);
        repeat (5) queue_item(2'd1, 12'd4094, 1'b1, 1'b1);
        repeat (5) queue_item(2'd2, 12'd300, 1'b1, 1'b1);
        queue_item(2'd3, 12'd4095, 1'b1, 1'b1);       // falls in no window
        queue_item(2'd3, 12'd1499, 1'b1, 1'b1);       // just below the normal window
        repeat (5) queue_item(2'd0, 12'd2000, 1'b1, 1'b1);
        random_traffic(170, 6);

        // Overlapping windows to exercise priority; zero open count confirms at once.
        wait_drained();
        program_windows(100, 1000, 1200, 1100, 1300, 900, 1400, 0);
        set_idling(66, 0);
        random_traffic(190, 4);

        // Upper extremes: everything below full scale is open, confirm count 63.
        wait_drained();
        program_windows(4095, 4095, 4095, 4095, 4095, 4095, 4095, 63);
        set_idling(0, 66);
        random_traffic(190, 70);

        // Lower extremes with a long receiver hold-off at the start.
        wait_drained();
        program_windows(0, 0, 50, 3000, 4095, 0, 4095, 1);
        set_idling(32, 32);
        pressure_go = 1'b1;
        random_traffic(190, 4);

        wait_drained();
        program_windows(150, 3500, 4000, 50, 600, 1000, 3000, 12);
        set_idling(0, 66);
        random_traffic(190, 16);

        wait_drained();
        if (mismatch_count == 0 && expected_status.size() == 0)
            $display("tb_camera_line_fault_debouncer_unit: clean");
        else
            $display("tb_camera_line_fault_debouncer_unit: errors");
        $finish;
    end

endmodule

// ===== camera_line_fault_debouncer_unit.f =====
sv/clfd_pkg.sv
sv/clfd_regs.sv
sv/clfd_engine.sv
sv/camera_line_fault_debouncer_unit.sv
tb/tb_camera_line_fault_debouncer_unit.sv
